[rtl/line_assembling_receive_fifo_core_defines.svh]
// assertion helpers for the receive fifo core
`ifndef LINE_ASSEMBLING_RECEIVE_FIFO_CORE_DEFINES_SVH
`define LINE_ASSEMBLING_RECEIVE_FIFO_CORE_DEFINES_SVH

// same-cycle implication, off while reset is high
`define LARF_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("receive fifo core: same-cycle check failed");

// next-cycle implication, off while reset is high
`define LARF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("receive fifo core: next-cycle check failed");

`endif

[rtl/larf_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package larf_pkg;

  localparam int BYTE_W = 8;
  localparam int LEN_W  = 6;
  localparam int ST_W   = 2;

  typedef enum logic [1:0] {
    OP_PUSH     = 2'd0,
    OP_POP_BYTE = 2'd1,
    OP_POP_LINE = 2'd2,
    OP_RSVD     = 2'd3
  } op_t;

  localparam logic [ST_W-1:0] STAT_OK      = 2'd0;
  localparam logic [ST_W-1:0] STAT_REFUSED = 2'd1;
  localparam logic [ST_W-1:0] STAT_EMPTY   = 2'd2;

  localparam logic [BYTE_W-1:0] CHAR_NUL = 8'h00;
  localparam logic [BYTE_W-1:0] CHAR_LF  = 8'h0a;
  localparam logic [BYTE_W-1:0] CHAR_CR  = 8'h0d;

  function automatic logic is_delim(input logic [BYTE_W-1:0] b);
    return (b == CHAR_NUL) || (b == CHAR_LF) || (b == CHAR_CR);
  endfunction

endpackage
`default_nettype wire

[rtl/line_assembling_receive_fifo_core.sv]
`timescale 1ns / 1ps
`default_nettype none
// byte ring with line extraction, one command beat in, one or more result beats out
// s_axis: tuser carries the command (push, pop byte, pop line), tdata the pushed
//   byte, tlast marks the final byte of a received packet
// m_axis: tdata carries the byte and the line length, tuser the status and the
//   data-arrived notify flag, tlast marks the final result beat of a command
// a push or an unused command gives its result in the register the cycle after
//   acceptance; the next command can be taken in that same cycle
// a byte pop first reads the ring memory, then loads the result;
//   on an empty ring it answers at once with the empty status
// a line pop first skips leading delimiters, then scans the line bytes up to the
//   next delimiter, then emits the line bytes one per result beat; when no
//   delimiter follows the line it answers with the empty status; the single read
//   port of the ring memory sets this step-by-step order
// reset clears both indices, the drop flag, the state and the result valid; ring
//   contents are left as they are, since only written entries are ever read
// when m_axis_tready is low the result register holds its beat, the sequencer
//   waits on it and no new command is accepted until the beat can move
module line_assembling_receive_fifo_core #(
  parameter int DEPTH = 64
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  input  wire logic [larf_pkg::BYTE_W-1:0]    s_axis_tdata,   // [7:0] data_byte
  input  wire logic [1:0]                     s_axis_tuser,   // [1:0] op
  input  wire logic                           s_axis_tlast,   // batch_last
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  output logic [15:0]                         m_axis_tdata,   // [7:0] out_byte, [13:8] line_length
  output logic [2:0]                          m_axis_tuser,   // [1:0] status, [2] notify
  output logic                                m_axis_tlast    // last
);
  import larf_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP_RD,
    S_SKIP,
    S_SCAN,
    S_EMIT
  } state_t;

  function automatic logic [IDX_W-1:0] adv(input logic [IDX_W-1:0] i);
    return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
  endfunction

  state_t             state, state_next;
  logic [IDX_W-1:0]   read_index, read_index_next;
  logic [IDX_W-1:0]   write_index, write_index_next;
  logic [IDX_W-1:0]   pos, pos_next;
  logic [LEN_W-1:0]   len, len_next;
  logic [LEN_W-1:0]   rem, rem_next;
  logic               dropping, dropping_next;

  logic               out_valid, out_valid_next;
  logic [ST_W-1:0]    out_status, out_status_next;
  logic [BYTE_W-1:0]  out_byte, out_byte_next;
  logic [LEN_W-1:0]   out_len, out_len_next;
  logic               out_last, out_last_next;
  logic               out_notify, out_notify_next;

  logic [BYTE_W-1:0]  ring [DEPTH];
  logic [IDX_W-1:0]   raddr;
  logic [BYTE_W-1:0]  rdata;
  logic               mem_we;

  logic               slot_free;
  logic               in_acc;
  op_t                in_op;
  logic               ring_empty;
  logic               ring_full;
  logic               push_refused;
  logic               pop_load;

  assign slot_free     = !out_valid || m_axis_tready;
  assign s_axis_tready = (state == S_IDLE) && slot_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_op         = op_t'(s_axis_tuser);
  assign ring_empty    = (read_index == write_index);
  assign ring_full     = (adv(write_index) == read_index);
  assign push_refused  = in_acc && (in_op == OP_PUSH) && (dropping || ring_full);
  assign pop_load      = (state == S_POP_RD) && slot_free;

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {2'b00, out_len, out_byte};
  assign m_axis_tuser  = {out_notify, out_status};
  assign m_axis_tlast  = out_last;

  always_comb begin
    state_next       = state;
    read_index_next  = read_index;
    write_index_next = write_index;
    pos_next         = pos;
    len_next         = len;
    rem_next         = rem;
    dropping_next    = dropping;
    raddr            = read_index;
    mem_we           = 1'b0;

    // a new beat loads the result register; otherwise a taken beat frees it
    out_valid_next   = out_valid && !m_axis_tready;
    out_status_next  = out_status;
    out_byte_next    = out_byte;
    out_len_next     = out_len;
    out_last_next    = out_last;
    out_notify_next  = out_notify;

    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          out_valid_next  = 1'b1;
          out_status_next = STAT_OK;
          out_byte_next   = '0;
          out_len_next    = '0;
          out_last_next   = 1'b1;
          out_notify_next = 1'b0;
          unique case (in_op)
            OP_PUSH: begin
              out_notify_next = s_axis_tlast;
              if (dropping || ring_full) begin
                out_status_next = STAT_REFUSED;
                dropping_next   = 1'b1;
              end else begin
                mem_we           = 1'b1;
                write_index_next = adv(write_index);
              end
              if (s_axis_tlast) begin
                dropping_next = 1'b0;
              end
            end
            OP_POP_BYTE: begin
              if (ring_empty) begin
                out_status_next = STAT_EMPTY;
              end else begin
                out_valid_next = 1'b0;
                state_next     = S_POP_RD;
              end
            end
            OP_POP_LINE: begin
              out_valid_next = 1'b0;
              state_next     = S_SKIP;
            end
            OP_RSVD: begin
            end
            default: begin
            end
          endcase
        end
      end

      S_POP_RD: begin
        if (slot_free) begin
          out_valid_next  = 1'b1;
          out_status_next = STAT_OK;
          out_byte_next   = rdata;
          out_len_next    = '0;
          out_last_next   = 1'b1;
          out_notify_next = 1'b0;
          read_index_next = adv(read_index);
          state_next      = S_IDLE;
        end
      end

      // rdata holds ring[read_index]
      S_SKIP: begin
        if (ring_empty) begin
          if (slot_free) begin
            out_valid_next  = 1'b1;
            out_status_next = STAT_EMPTY;
            out_byte_next   = '0;
            out_len_next    = '0;
            out_last_next   = 1'b1;
            out_notify_next = 1'b0;
            state_next      = S_IDLE;
          end
        end else if (is_delim(rdata)) begin
          read_index_next = adv(read_index);
          raddr           = adv(read_index);
        end else begin
          pos_next   = adv(read_index);
          len_next   = LEN_W'(1);
          raddr      = adv(read_index);
          state_next = S_SCAN;
        end
      end

      // rdata holds ring[pos]
      S_SCAN: begin
        raddr = pos;
        if (pos == write_index) begin
          if (slot_free) begin
            out_valid_next  = 1'b1;
            out_status_next = STAT_EMPTY;
            out_byte_next   = '0;
            out_len_next    = '0;
            out_last_next   = 1'b1;
            out_notify_next = 1'b0;
            state_next      = S_IDLE;
          end
        end else if (is_delim(rdata)) begin
          rem_next   = len;
          raddr      = read_index;
          state_next = S_EMIT;
        end else begin
          len_next = len + 1'b1;
          pos_next = adv(pos);
          raddr    = adv(pos);
        end
      end

      // rdata holds ring[read_index]
      S_EMIT: begin
        if (slot_free) begin
          out_valid_next  = 1'b1;
          out_status_next = STAT_OK;
          out_byte_next   = rdata;
          out_len_next    = len;
          out_last_next   = (rem == LEN_W'(1));
          out_notify_next = 1'b0;
          read_index_next = adv(read_index);
          raddr           = adv(read_index);
          rem_next        = rem - 1'b1;
          if (rem == LEN_W'(1)) begin
            state_next = S_IDLE;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // ring memory, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[write_index] <= s_axis_tdata;
    end
    rdata <= ring[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      read_index  <= '0;
      write_index <= '0;
      dropping    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      read_index  <= read_index_next;
      write_index <= write_index_next;
      dropping    <= dropping_next;
      out_valid   <= out_valid_next;
    end
    pos        <= pos_next;
    len        <= len_next;
    rem        <= rem_next;
    out_status <= out_status_next;
    out_byte   <= out_byte_next;
    out_len    <= out_len_next;
    out_last   <= out_last_next;
    out_notify <= out_notify_next;
  end

`include "line_assembling_receive_fifo_core_defines.svh"

  // a refused push never moves the write index
  `LARF_ASSERT_NEXT(a_refused_push_holds, clk, rst, push_refused, write_index == $past(write_index))
  // emitting a line always has bytes left to send
  `LARF_ASSERT_NOW(a_emit_nonzero, clk, rst, state == S_EMIT, rem != '0)
  // a scan has already counted its first line byte
  `LARF_ASSERT_NOW(a_scan_counted, clk, rst, state == S_SCAN, len != '0)
  // a loaded byte pop consumes exactly one entry
  `LARF_ASSERT_NEXT(a_pop_advances, clk, rst, pop_load, read_index == adv($past(read_index)))

endmodule
`default_nettype wire
